@@ design/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Command and status codes, and the word that travels along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int CMD_W  = 2;
    localparam int SIZE_W = 16;
    localparam int ID_W   = 5;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_e_t;

    typedef struct packed {
        status_e_t         status;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } result_t;

    typedef struct packed {
        logic              active;
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] req_size;
        logic [ID_W-1:0]   block_id;
        logic              done;
        result_t           res;
    } token_t;

endpackage

`default_nettype wire

@@ design/ffba_cell.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator cell
// Holds one table entry and serves the command word as it passes by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_cell #(
    parameter int INDEX     = 0,
    parameter int SIZE_BITS = 16,
    parameter int COUNT_W   = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ffba_pkg::token_t   tok_in,
    input  wire logic [COUNT_W-1:0] count,
    output ffba_pkg::token_t        tok_out
);

    localparam int CMP_W = (SIZE_BITS > ffba_pkg::SIZE_W) ? SIZE_BITS : ffba_pkg::SIZE_W;
    localparam int IDX_CMP_W = COUNT_W + 2;

    logic [SIZE_BITS-1:0] size_reg;
    logic                 free_reg;
    ffba_pkg::token_t     tok_reg;
    ffba_pkg::token_t     tok_next;

    logic size_we;
    logic free_we;
    logic free_val;
    logic at_tail;
    logic in_use;
    logic id_match;
    logic fits;

    assign at_tail  = (count == COUNT_W'(INDEX));
    assign in_use   = (COUNT_W'(INDEX) < count);
    assign id_match = (IDX_CMP_W'(tok_in.block_id) == IDX_CMP_W'(INDEX + 1));
    assign fits     = (CMP_W'(size_reg) >= CMP_W'(tok_in.req_size));

    always_comb
    begin
        tok_next = tok_in;
        size_we  = 1'b0;
        free_we  = 1'b0;
        free_val = 1'b0;
        if (tok_in.active && !tok_in.done)
        begin
            case (tok_in.cmd)
                ffba_pkg::CMD_ADD:
                begin
                    if (at_tail)
                    begin
                        size_we           = 1'b1;
                        free_we           = 1'b1;
                        free_val          = 1'b1;
                        tok_next.done     = 1'b1;
                        tok_next.res      = '{ffba_pkg::ST_OK,
                                              ffba_pkg::ID_W'(INDEX + 1),
                                              tok_in.req_size};
                    end
                end
                ffba_pkg::CMD_ALLOC:
                begin
                    if (in_use && free_reg && fits)
                    begin
                        free_we           = 1'b1;
                        free_val          = 1'b0;
                        tok_next.done     = 1'b1;
                        tok_next.res      = '{ffba_pkg::ST_OK,
                                              ffba_pkg::ID_W'(INDEX + 1),
                                              ffba_pkg::SIZE_W'(size_reg)};
                    end
                end
                ffba_pkg::CMD_FREE:
                begin
                    if (in_use && id_match && !free_reg)
                    begin
                        free_we           = 1'b1;
                        free_val          = 1'b1;
                        tok_next.done     = 1'b1;
                        tok_next.res      = '{ffba_pkg::ST_OK,
                                              ffba_pkg::ID_W'(INDEX + 1),
                                              ffba_pkg::SIZE_W'(size_reg)};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_reg <= SIZE_BITS'(tok_in.req_size);
        end
        if (free_we)
        begin
            free_reg <= free_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ design/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator
// Keeps an append-ordered table of blocks, each a size and a free mark, in a
// row of MAX_BLOCKS cells. Each accepted word (add, allocate or free) walks
// the row one cell per cycle, and its result word is registered at the output
// after it leaves the last cell. The next command is taken only once the
// previous one has left the last cell and no result word waits in the hold
// register, so only one command is in the row at a time. One result word can wait at the
// output while the next command runs. Block identifiers are one-based.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ffba_pkg::CMD_W-1:0]    command,
    input  wire logic [ffba_pkg::SIZE_W-1:0]   size,
    input  wire logic [ffba_pkg::ID_W-1:0]     block_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic [ffba_pkg::ID_W-1:0]          result_id,
    output logic [ffba_pkg::SIZE_W-1:0]        result_size
);

    localparam int COUNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [ffba_pkg::SIZE_W-1:0] REQ_MASK =
        (SIZE_BITS >= ffba_pkg::SIZE_W) ? {ffba_pkg::SIZE_W{1'b1}}
                                        : ffba_pkg::SIZE_W'((32'd1 << SIZE_BITS) - 32'd1);

    ffba_pkg::token_t tok [0:MAX_BLOCKS];
    ffba_pkg::token_t exit_tok;
    ffba_pkg::result_t exit_res;
    ffba_pkg::result_t out_word_reg;
    ffba_pkg::result_t hold_word_reg;

    logic [COUNT_W-1:0] count_reg;
    logic busy_reg;
    logic out_valid_reg;
    logic hold_valid_reg;
    logic accept;
    logic out_free;

    assign in_stall = busy_reg || hold_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        tok[0]          = '0;
        tok[0].active   = accept;
        tok[0].cmd      = command;
        tok[0].req_size = size & REQ_MASK;
        tok[0].block_id = block_id;
        tok[0].done     = 1'b0;
        tok[0].res      = '{ffba_pkg::ST_OK, '0, '0};
    end

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        ffba_cell #(
            .INDEX     (i),
            .SIZE_BITS (SIZE_BITS),
            .COUNT_W   (COUNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .count   (count_reg),
            .tok_out (tok[i+1])
        );
    end

    assign exit_tok = tok[MAX_BLOCKS];

    always_comb
    begin
        if (exit_tok.done)
        begin
            exit_res = exit_tok.res;
        end
        else if (exit_tok.cmd == ffba_pkg::CMD_ADD)
        begin
            exit_res = '{ffba_pkg::ST_FULL, '0, '0};
        end
        else if (exit_tok.cmd == ffba_pkg::CMD_ALLOC)
        begin
            exit_res = '{ffba_pkg::ST_NO_FIT, '0, '0};
        end
        else
        begin
            exit_res = '{ffba_pkg::ST_NOT_FOUND, '0, '0};
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_tok.active)
            begin
                busy_reg <= 1'b0;
            end

            if (exit_tok.active && exit_tok.done && (exit_tok.cmd == ffba_pkg::CMD_ADD))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (out_free)
            begin
                if (hold_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= exit_tok.active;
                end
                else
                begin
                    out_valid_reg <= exit_tok.active;
                end
            end
            else if (exit_tok.active)
            begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_word_reg <= hold_word_reg;
                if (exit_tok.active)
                begin
                    hold_word_reg <= exit_res;
                end
            end
            else if (exit_tok.active)
            begin
                out_word_reg <= exit_res;
            end
        end
        else if (exit_tok.active)
        begin
            hold_word_reg <= exit_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_word_reg.status;
    assign result_id   = out_word_reg.id;
    assign result_size = out_word_reg.size;

`ifndef SYNTHESIS
    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("Accepted word did not mark the block busy.");

    a_exit_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.active |-> (busy_reg && !hold_valid_reg))
        else $error("Result word left the chain with no room to land.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_BLOCKS))
        else $error("Block count exceeds table depth.");

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !accept)
        else $error("Word accepted while another is in the chain.");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives add, allocate and free words into the allocator with random idle
// gaps on the input and random stalls on the output. A scoreboard keeps its
// own copy of the block table, predicts the result of every accepted word and
// compares each result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_WORDS = 1920;
    localparam logic [ffba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    class alloc_scoreboard;
        logic [ffba_pkg::SIZE_W-1:0] sizes [TABLE_DEPTH];
        bit                          avail [TABLE_DEPTH];
        int unsigned                 used;
        ffba_pkg::result_t           due [$];
        int unsigned                 errors;
        int unsigned                 seen [4];

        function new();
            used = 0;
            errors = 0;
            foreach (seen[k]) seen[k] = 0;
            foreach (avail[k]) avail[k] = 1'b0;
            foreach (sizes[k]) sizes[k] = '0;
        endfunction

        function void note_command(logic [ffba_pkg::CMD_W-1:0] cmd,
                                   logic [ffba_pkg::SIZE_W-1:0] sz,
                                   logic [ffba_pkg::ID_W-1:0] id);
            ffba_pkg::result_t r;
            int                i;
            bit                found;
            r.status = ffba_pkg::ST_NOT_FOUND;
            r.id = '0;
            r.size = '0;
            found = 1'b0;
            case (cmd)
                ffba_pkg::CMD_ADD:
                begin
                    if (used >= TABLE_DEPTH) begin
                        r.status = ffba_pkg::ST_FULL;
                    end else begin
                        sizes[used] = sz;
                        avail[used] = 1'b1;
                        used++;
                        r.status = ffba_pkg::ST_OK;
                        r.id = ffba_pkg::ID_W'(used);
                        r.size = sz;
                    end
                end
                ffba_pkg::CMD_ALLOC:
                begin
                    r.status = ffba_pkg::ST_NO_FIT;
                    for (i = 0; i < used && !found; i++) begin
                        if (avail[i] && sizes[i] >= sz) begin
                            found = 1'b1;
                            avail[i] = 1'b0;
                            r.status = ffba_pkg::ST_OK;
                            r.id = ffba_pkg::ID_W'(i + 1);
                            r.size = sizes[i];
                        end
                    end
                end
                ffba_pkg::CMD_FREE:
                begin
                    if (id >= 1 && id <= used && !avail[id - 1]) begin
                        avail[id - 1] = 1'b1;
                        r.status = ffba_pkg::ST_OK;
                        r.id = id;
                        r.size = sizes[id - 1];
                    end
                end
                default:
                begin
                end
            endcase
            due.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [ffba_pkg::ID_W-1:0] id,
                                   logic [ffba_pkg::SIZE_W-1:0] sz);
            ffba_pkg::result_t r;
            if (due.size() == 0) begin
                $error("result word with no command pending: status %0d id %0d size %0d",
                       st, id, sz);
                errors++;
                return;
            end
            r = due.pop_front();
            seen[r.status]++;
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (id !== r.id) begin
                $error("result_id: expected %0d, got %0d", r.id, id);
                errors++;
            end
            if (sz !== r.size) begin
                $error("result_size: expected %0d, got %0d", r.size, sz);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [ffba_pkg::CMD_W-1:0]  command;
    logic [ffba_pkg::SIZE_W-1:0] size;
    logic [ffba_pkg::ID_W-1:0]   block_id;
    logic                        out_valid;
    logic                        out_stall;
    logic [1:0]                  status;
    logic [ffba_pkg::ID_W-1:0]   result_id;
    logic [ffba_pkg::SIZE_W-1:0] result_size;

    bit              no_idle;
    alloc_scoreboard sb;

    first_fit_block_allocator #(
        .MAX_BLOCKS(TABLE_DEPTH),
        .SIZE_BITS (ffba_pkg::SIZE_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .size       (size),
        .block_id   (block_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .result_id  (result_id),
        .result_size(result_size)
    );

    always #5 clk = ~clk;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue(input logic [ffba_pkg::CMD_W-1:0] cmd,
                         input logic [ffba_pkg::SIZE_W-1:0] sz,
                         input logic [ffba_pkg::ID_W-1:0] id);
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        size     <= sz;
        block_id <= id;
        do @(posedge clk); while (in_stall);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_command(command, size, block_id);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, result_id, result_size);
    end

    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            hold = no_idle ? 0 : idle_len();
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic [ffba_pkg::CMD_W-1:0]  cmd;
        logic [ffba_pkg::SIZE_W-1:0] sz;
        logic [ffba_pkg::ID_W-1:0]   id;
        int unsigned                 r;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = ffba_pkg::CMD_ADD;
        size      = '0;
        block_id  = '0;
        out_stall = 1'b0;
        no_idle   = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(ffba_pkg::CMD_ALLOC, 16'd0, 5'd0);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd0);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd1);
        issue(CMD_UNUSED, 16'hFFFF, 5'h1F);
        issue(ffba_pkg::CMD_ADD, 16'hFFFF, 5'h1F);
        issue(ffba_pkg::CMD_ADD, 16'd0, 5'd0);
        issue(ffba_pkg::CMD_ALLOC, 16'hFFFF, 5'd0);
        issue(ffba_pkg::CMD_ALLOC, 16'd1, 5'd0);
        issue(ffba_pkg::CMD_ALLOC, 16'd0, 5'd0);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd1);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd1);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd3);
        for (int k = 0; k < TABLE_DEPTH - 2; k++)
            issue(ffba_pkg::CMD_ADD, ffba_pkg::SIZE_W'($urandom) >> $urandom_range(0, 15),
                  ffba_pkg::ID_W'($urandom));
        issue(ffba_pkg::CMD_ADD, 16'h8000, 5'd0);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd16);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd17);
        issue(ffba_pkg::CMD_FREE, 16'd0, 5'd31);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            sz = ffba_pkg::SIZE_W'($urandom);
            id = ffba_pkg::ID_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                cmd = ffba_pkg::CMD_ALLOC;
                case ($urandom_range(0, 3))
                    0: sz = ffba_pkg::SIZE_W'($urandom);
                    1: sz = sb.sizes[$urandom_range(0, TABLE_DEPTH - 1)];
                    2: sz = sb.sizes[$urandom_range(0, TABLE_DEPTH - 1)] + 16'd1;
                    default: sz = ffba_pkg::SIZE_W'($urandom_range(0, 15));
                endcase
            end
            else if (r < 85)
            begin
                cmd = ffba_pkg::CMD_FREE;
                if ($urandom_range(0, 4) != 0)
                    id = ffba_pkg::ID_W'($urandom_range(1, TABLE_DEPTH));
            end
            else if (r < 93)
            begin
                cmd = ffba_pkg::CMD_ADD;
            end
            else
            begin
                cmd = CMD_UNUSED;
            end
            issue(cmd, sz, id);
        end
        in_valid <= 1'b0;

        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (3 * (TABLE_DEPTH + 1)) @(posedge clk);

        $display("Results: %0d ok, %0d no fit, %0d not found or already free, %0d table full.",
                 sb.seen[ffba_pkg::ST_OK], sb.seen[ffba_pkg::ST_NO_FIT],
                 sb.seen[ffba_pkg::ST_NOT_FOUND], sb.seen[ffba_pkg::ST_FULL]);
        $display("Mismatches and unexpected result words: %0d.", sb.errors);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
